>>> hdl/udsn_pkg.sv
// shared types, byte constants and sequence matching functions for the space normalizer
package udsn_pkg;

    localparam int MAX_RES    = 3;
    localparam int OB_DEPTH   = 4;
    localparam int OCC_W      = $clog2(OB_DEPTH + 1);
    localparam int ROOM_LIMIT = OB_DEPTH - MAX_RES;

    localparam logic [15:0] REPORT_MAX = 16'hFFFF;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] LEAD_E1  = 8'hE1;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam logic [7:0] LEAD_E3  = 8'hE3;
    localparam logic [7:0] LEAD_EF  = 8'hEF;
    localparam logic [7:0] CONT_80  = 8'h80;
    localparam logic [7:0] CONT_81  = 8'h81;
    localparam logic [7:0] CONT_9A  = 8'h9A;
    localparam logic [7:0] CONT_A0  = 8'hA0;
    localparam logic [7:0] CONT_AD  = 8'hAD;
    localparam logic [7:0] CONT_BB  = 8'hBB;
    localparam logic [7:0] CONT_BF  = 8'hBF;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SPACE,
        ACT_REMOVE
    } act_t;

    typedef struct packed {
        logic [1:0] len;
        act_t       act;
    } cls_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        vld;
        logic        last;
        logic [15:0] cnt;
    } result_t;

    function automatic cls_t classify(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [1:0] n);
        cls_t r;
        r.len = 2'd1;
        r.act = ACT_NONE;
        if (b0 == CH_TAB || b0 == CH_CR || b0 == CH_LF)
        begin
            r.act = ACT_SPACE;
        end
        else if (n >= 2'd2 && b0 == LEAD_C2 && b1 == CONT_A0)
        begin
            r.act = ACT_SPACE;
            r.len = 2'd2;
        end
        else if (n >= 2'd2 && b0 == LEAD_C2 && b1 == CONT_AD)
        begin
            r.act = ACT_REMOVE;
            r.len = 2'd2;
        end
        else if (n == 2'd3)
        begin
            if (b0 == LEAD_E1 && b1 == CONT_9A && b2 == CONT_80)
                r.act = ACT_SPACE;
            else if (b0 == LEAD_E2 && b1 == CONT_80 &&
                     ((b2 >= 8'h80 && b2 <= 8'h8A) || b2 == 8'hA8 || b2 == 8'hA9 ||
                      b2 == 8'hAF))
                r.act = ACT_SPACE;
            else if (b0 == LEAD_E2 && b1 == CONT_80 &&
                     ((b2 >= 8'h8B && b2 <= 8'h8F) || (b2 >= 8'hAA && b2 <= 8'hAE)))
                r.act = ACT_REMOVE;
            else if (b0 == LEAD_E2 && b1 == CONT_81 && b2 == 8'h9F)
                r.act = ACT_SPACE;
            else if (b0 == LEAD_E2 && b1 == CONT_81 && b2 >= 8'hA0 && b2 <= 8'hAF)
                r.act = ACT_REMOVE;
            else if (b0 == LEAD_E3 && b1 == CONT_80 && b2 == CONT_80)
                r.act = ACT_SPACE;
            else if (b0 == LEAD_EF && b1 == CONT_BB && b2 == CONT_BF)
                r.act = ACT_REMOVE;
            if (r.act != ACT_NONE)
                r.len = 2'd3;
        end
        return r;
    endfunction

    function automatic logic is_prefix(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [1:0] n);
        logic r;
        r = 1'b0;
        if (n == 2'd1)
            r = (b0 == LEAD_C2 || b0 == LEAD_E1 || b0 == LEAD_E2 || b0 == LEAD_E3 ||
                 b0 == LEAD_EF);
        else if (n == 2'd2)
            r = (b0 == LEAD_E1 && b1 == CONT_9A) ||
                (b0 == LEAD_E2 && (b1 == CONT_80 || b1 == CONT_81)) ||
                (b0 == LEAD_E3 && b1 == CONT_80) ||
                (b0 == LEAD_EF && b1 == CONT_BB);
        return r;
    endfunction

endpackage

>>> hdl/udsn_matcher.sv
// sequence matcher with held prefix bytes and saturating change counter
module udsn_matcher import udsn_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [7:0]                  item_data,
    input  logic                        item_last,
    output result_t [MAX_RES-1:0]       res,
    output logic [1:0]                  res_n
);

    localparam int RW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [7:0]             pend_reg [2];
    logic [7:0]             pend_next [2];
    logic [1:0]             pend_cnt_reg;
    logic [1:0]             pend_cnt_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;

    logic [7:0]             win [3];
    logic [7:0]             emit [3];
    logic [1:0]             n_w;
    logic [1:0]             ne;
    logic [1:0]             bumps;
    logic [1:0]             step_len;
    logic                   held;
    cls_t                   cls;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    logic [RW-1:0]          cnt_ext;
    logic [15:0]            cnt_rep;

    always_comb
    begin
        win[0] = pend_reg[0];
        win[1] = pend_reg[1];
        win[2] = 8'h00;
        unique case (pend_cnt_reg)
            2'd0:
            begin
                win[0] = item_data;
                n_w    = 2'd1;
            end
            2'd1:
            begin
                win[1] = item_data;
                n_w    = 2'd2;
            end
            default:
            begin
                win[2] = item_data;
                n_w    = 2'd3;
            end
        endcase

        ne       = 2'd0;
        bumps    = 2'd0;
        held     = 1'b0;
        step_len = 2'd1;
        cls      = '{len: 2'd1, act: ACT_NONE};
        for (int k = 0; k < MAX_RES; k++)
            emit[k] = 8'h00;

        // up to three tokens per byte, each step consumes one to three bytes
        for (int it = 0; it < MAX_RES; it++)
        begin
            if (n_w != 2'd0 && !held)
            begin
                cls      = classify(win[0], win[1], win[2], n_w);
                step_len = cls.len;
                if (cls.act == ACT_NONE)
                begin
                    if (!item_last && is_prefix(win[0], win[1], n_w))
                    begin
                        held = 1'b1;
                    end
                    else
                    begin
                        emit[ne] = win[0];
                        ne       = ne + 2'd1;
                        step_len = 2'd1;
                    end
                end
                else
                begin
                    if (cls.act == ACT_SPACE)
                    begin
                        emit[ne] = CH_SPACE;
                        ne       = ne + 2'd1;
                    end
                    bumps = bumps + 2'd1;
                end
                if (!held)
                begin
                    unique case (step_len)
                        2'd1:
                        begin
                            win[0] = win[1];
                            win[1] = win[2];
                            win[2] = 8'h00;
                        end
                        2'd2:
                        begin
                            win[0] = win[2];
                            win[1] = 8'h00;
                            win[2] = 8'h00;
                        end
                        default:
                        begin
                            win[0] = 8'h00;
                            win[1] = 8'h00;
                            win[2] = 8'h00;
                        end
                    endcase
                    n_w = n_w - step_len;
                end
            end
        end
    end

    always_comb
    begin
        cnt_sum = {1'b0, cnt_reg} + (COUNT_WIDTH + 1)'(bumps);
        cnt_sat = cnt_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : cnt_sum[COUNT_WIDTH-1:0];
        cnt_ext = RW'(cnt_sat);
        cnt_rep = (cnt_ext > RW'(REPORT_MAX)) ? REPORT_MAX : cnt_ext[15:0];
    end

    always_comb
    begin
        res_n = ne;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = '0;
            if (2'(k) < ne)
            begin
                res[k].data = emit[k];
                res[k].vld  = 1'b1;
            end
        end
        if (item_last)
        begin
            if (ne == 2'd0)
            begin
                res[0].last = 1'b1;
                res[0].cnt  = cnt_rep;
                res_n       = 2'd1;
            end
            else
            begin
                for (int k = 0; k < MAX_RES; k++)
                begin
                    if (2'(k) == ne - 2'd1)
                    begin
                        res[k].last = 1'b1;
                        res[k].cnt  = cnt_rep;
                    end
                end
            end
        end
    end

    always_comb
    begin
        pend_next[0]  = pend_reg[0];
        pend_next[1]  = pend_reg[1];
        pend_cnt_next = pend_cnt_reg;
        cnt_next      = cnt_reg;
        if (item_valid)
        begin
            if (item_last)
            begin
                pend_next[0]  = 8'h00;
                pend_next[1]  = 8'h00;
                pend_cnt_next = 2'd0;
                cnt_next      = '0;
            end
            else
            begin
                pend_next[0]  = (n_w > 2'd0) ? win[0] : 8'h00;
                pend_next[1]  = (n_w > 2'd1) ? win[1] : 8'h00;
                pend_cnt_next = n_w;
                cnt_next      = cnt_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg[0]  <= 8'h00;
            pend_reg[1]  <= 8'h00;
            pend_cnt_reg <= 2'd0;
            cnt_reg      <= '0;
        end
        else
        begin
            pend_reg[0]  <= pend_next[0];
            pend_reg[1]  <= pend_next[1];
            pend_cnt_reg <= pend_cnt_next;
            cnt_reg      <= cnt_next;
        end
    end

    a_pend_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg != 2'd3)
        else $error("held byte count out of range");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_last |=> pend_cnt_reg == 2'd0 && cnt_reg == '0)
        else $error("state not cleared after final byte");

endmodule

>>> hdl/udsn_outbuf.sv
// result buffer taking up to three results per cycle, giving one if unstalled
module udsn_outbuf import udsn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_en,
    input  logic [1:0]            push_n,
    input  result_t [MAX_RES-1:0] push_data,
    output logic                  room,
    output logic                  head_valid,
    input  logic                  head_stall,
    output result_t               head
);

    result_t          ent_reg [OB_DEPTH];
    result_t          ent_next [OB_DEPTH];
    result_t          base [OB_DEPTH];
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [OCC_W-1:0] occ_base;
    logic             pop;

    assign head_valid = (occ_reg != '0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && !head_stall;
    assign room       = (occ_reg <= OCC_W'(ROOM_LIMIT));

    always_comb
    begin
        for (int j = 0; j < OB_DEPTH; j++)
            base[j] = ent_reg[j];
        occ_base = occ_reg;
        if (pop)
        begin
            for (int j = 0; j < OB_DEPTH - 1; j++)
                base[j] = ent_reg[j + 1];
            occ_base = occ_reg - OCC_W'(1);
        end

        for (int j = 0; j < OB_DEPTH; j++)
        begin
            ent_next[j] = base[j];
            for (int k = 0; k < MAX_RES; k++)
            begin
                if (push_en && OCC_W'(k) < OCC_W'(push_n) &&
                    occ_base + OCC_W'(k) == OCC_W'(j))
                    ent_next[j] = push_data[k];
            end
        end
        occ_next = push_en ? occ_base + OCC_W'(push_n) : occ_base;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < OB_DEPTH; j++)
            ent_reg[j] <= ent_next[j];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(OB_DEPTH))
        else $error("result buffer overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> room)
        else $error("results pushed without room");

endmodule

>>> hdl/utf8_display_space_normalizer_unit.sv
// top level of the utf-8 display space normalizer
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  input    | in_valid / in_stall   | in_byte, in_last
//  result   | res_valid / res_stall | out_byte, out_valid, out_last, changed_count
//
// one byte per cycle unless in_stall is high; input register feeds the result buffer
// a byte yielding two or three results gives them one after another on the result port,
// from the four-entry result buffer, which takes a new byte only at one entry or less
// in_stall comes from registers only; res_stall has no combinational path to the input
// asynchronous active-low reset empties the input register and result buffer and
// clears the held bytes and change counter
module utf8_display_space_normalizer_unit import udsn_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        out_last,
    output logic [15:0] changed_count
);

    logic                  in_full_reg;
    logic                  in_full_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  accept;
    logic                  advance;
    logic                  room;
    result_t [MAX_RES-1:0] res;
    logic [1:0]            res_n;
    result_t               head;

    assign advance  = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    udsn_matcher #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_matcher (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item_data  (in_byte_reg),
        .item_last  (in_last_reg),
        .res        (res),
        .res_n      (res_n)
    );

    udsn_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (advance),
        .push_n     (res_n),
        .push_data  (res),
        .room       (room),
        .head_valid (res_valid),
        .head_stall (res_stall),
        .head       (head)
    );

    assign out_byte      = head.data;
    assign out_valid     = head.vld;
    assign out_last      = head.last;
    assign changed_count = head.cnt;

    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !advance |=> in_full_reg && $stable(in_byte_reg) &&
        $stable(in_last_reg))
        else $error("waiting input transaction lost");

endmodule

>>> bench/utf8_display_space_normalizer_unit_tb.sv
// self-checking testbench for the utf-8 display space normalizer unit
`timescale 1ns / 1ps

module utf8_display_space_normalizer_unit_tb;
    import udsn_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } feed_t;

    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        out_last;
    logic [15:0] changed_count;

    feed_t       item_q [$];
    logic [7:0]  text_q [$];
    result_t     exp_q [$];

    logic [7:0]  held [0:1];
    int          held_n = 0;
    logic [15:0] chg_total = 16'h0000;

    bit          in_took = 1'b0;
    bit          long_hold = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          stim_phase = 0;
    int          taken_cnt = 0;
    int          fed_cnt = 0;
    int          err_cnt = 0;

    utf8_display_space_normalizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .in_last       (in_last),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .out_last      (out_last),
        .changed_count (changed_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    // length of a complete token at the window head, with its action
    function automatic int match_token(input logic [7:0] w0, input logic [7:0] w1,
                                       input logic [7:0] w2, input int n, output act_t act);
        act = ACT_NONE;
        if (w0 == CH_TAB || w0 == CH_CR || w0 == CH_LF)
        begin
            act = ACT_SPACE;
            return 1;
        end
        if (n >= 2 && w0 == LEAD_C2)
        begin
            if (w1 == CONT_A0)
                act = ACT_SPACE;
            else if (w1 == CONT_AD)
                act = ACT_REMOVE;
            if (act != ACT_NONE)
                return 2;
        end
        if (n < 3)
            return 1;
        case (w0)
            LEAD_E1:
                if (w1 == CONT_9A && w2 == CONT_80)
                    act = ACT_SPACE;
            LEAD_E2:
                if (w1 == CONT_80)
                begin
                    if (w2 inside {[8'h80:8'h8A], 8'hA8, 8'hA9, 8'hAF})
                        act = ACT_SPACE;
                    else if (w2 inside {[8'h8B:8'h8F], [8'hAA:8'hAE]})
                        act = ACT_REMOVE;
                end
                else if (w1 == CONT_81)
                begin
                    if (w2 == 8'h9F)
                        act = ACT_SPACE;
                    else if (w2 inside {[8'hA0:8'hAF]})
                        act = ACT_REMOVE;
                end
            LEAD_E3:
                if (w1 == CONT_80 && w2 == CONT_80)
                    act = ACT_SPACE;
            LEAD_EF:
                if (w1 == CONT_BB && w2 == CONT_BF)
                    act = ACT_REMOVE;
            default: ;
        endcase
        return (act == ACT_NONE) ? 1 : 3;
    endfunction

    function automatic bit could_extend(input logic [7:0] w0, input logic [7:0] w1,
                                        input int n);
        if (n == 1)
            return w0 inside {LEAD_C2, LEAD_E1, LEAD_E2, LEAD_E3, LEAD_EF};
        if (n == 2)
            return (w0 == LEAD_E1 && w1 == CONT_9A) ||
                   (w0 == LEAD_E2 && (w1 == CONT_80 || w1 == CONT_81)) ||
                   (w0 == LEAD_E3 && w1 == CONT_80) ||
                   (w0 == LEAD_EF && w1 == CONT_BB);
        return 1'b0;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic lst);
        logic [7:0] win [0:2];
        logic [7:0] emit [0:2];
        int n;
        int ne;
        int len;
        int k;
        act_t act;
        result_t r;
        win[0] = held[0];
        win[1] = held[1];
        win[2] = 8'h00;
        n = held_n;
        win[n] = b;
        n++;
        ne = 0;
        while (n > 0)
        begin
            len = match_token(win[0], win[1], win[2], n, act);
            if (act == ACT_NONE)
            begin
                if (!lst && could_extend(win[0], win[1], n))
                    break;
                len = 1;
                emit[ne] = win[0];
                ne++;
            end
            else
            begin
                if (act == ACT_SPACE)
                begin
                    emit[ne] = CH_SPACE;
                    ne++;
                end
                if (chg_total != REPORT_MAX)
                    chg_total++;
            end
            for (k = len; k < n; k++)
                win[k - len] = win[k];
            n -= len;
        end
        held_n = n;
        held[0] = (n > 0) ? win[0] : 8'h00;
        held[1] = (n > 1) ? win[1] : 8'h00;
        for (k = 0; k < ne; k++)
        begin
            r.data = emit[k];
            r.vld = 1'b1;
            r.last = lst && (k == ne - 1);
            r.cnt = r.last ? chg_total : 16'h0000;
            exp_q.push_back(r);
        end
        if (lst && ne == 0)
        begin
            r.data = 8'h00;
            r.vld = 1'b0;
            r.last = 1'b1;
            r.cnt = chg_total;
            exp_q.push_back(r);
        end
        if (lst)
        begin
            held_n = 0;
            held[0] = 8'h00;
            held[1] = 8'h00;
            chg_total = 16'h0000;
        end
    endtask

    task automatic seal_string();
        feed_t f;
        while (text_q.size() > 0)
        begin
            f.data = text_q.pop_front();
            f.last = (text_q.size() == 0);
            item_q.push_back(f);
            fed_cnt++;
        end
    endtask

    function automatic logic [7:0] any_lead();
        case ($urandom_range(0, 4))
            0: return LEAD_C2;
            1: return LEAD_E1;
            2: return LEAD_E2;
            3: return LEAD_E3;
            default: return LEAD_EF;
        endcase
    endfunction

    task automatic add_token();
        case ($urandom_range(0, 15))
            0:
                case ($urandom_range(0, 2))
                    0: text_q.push_back(CH_TAB);
                    1: text_q.push_back(CH_CR);
                    default: text_q.push_back(CH_LF);
                endcase
            1, 2: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            3: text_q.push_back(8'($urandom_range(0, 255)));
            4:
            begin
                text_q.push_back(LEAD_C2);
                case ($urandom_range(0, 2))
                    0: text_q.push_back(CONT_A0);
                    1: text_q.push_back(CONT_AD);
                    default: text_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            5:
            begin
                text_q.push_back(LEAD_E1);
                text_q.push_back(CONT_9A);
                text_q.push_back($urandom_range(0, 2) != 0 ? CONT_80
                                                           : 8'($urandom_range(0, 255)));
            end
            6, 7:
            begin
                text_q.push_back(LEAD_E2);
                text_q.push_back(CONT_80);
                text_q.push_back(8'($urandom_range(8'h80, 8'hAF)));
            end
            8:
            begin
                text_q.push_back(LEAD_E2);
                text_q.push_back(CONT_81);
                text_q.push_back(8'($urandom_range(8'h98, 8'hB0)));
            end
            9:
            begin
                text_q.push_back(LEAD_E3);
                text_q.push_back(CONT_80);
                text_q.push_back(CONT_80);
            end
            10:
            begin
                text_q.push_back(LEAD_EF);
                text_q.push_back(CONT_BB);
                text_q.push_back(CONT_BF);
            end
            11:
            begin
                text_q.push_back(any_lead());
                text_q.push_back(8'($urandom_range(0, 255)));
            end
            12: text_q.push_back(any_lead());
            13:
            begin
                text_q.push_back(LEAD_E2);
                text_q.push_back($urandom_range(0, 1) ? CONT_80 : CONT_81);
                text_q.push_back(8'($urandom_range(0, 255)));
            end
            14:
            begin
                text_q.push_back(LEAD_E2);
                text_q.push_back(CONT_81);
                text_q.push_back(8'h9F);
            end
            default: text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
        endcase
    endtask

    task automatic run_random(input int n_items);
        int target;
        int n_tok;
        target = fed_cnt + n_items;
        while (fed_cnt < target)
        begin
            n_tok = $urandom_range(1, 8);
            repeat (n_tok) add_token();
            seal_string();
        end
    endtask

    task automatic drain_all();
        while (item_q.size() != 0 || in_valid || exp_q.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        feed_t nxt;
        if (!in_valid || in_took)
        begin
            if (item_q.size() > 0 && $urandom_range(0, 99) >= send_idle)
            begin
                nxt = item_q.pop_front();
                in_valid <= 1'b1;
                in_byte <= nxt.data;
                in_last <= nxt.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        res_stall <= long_hold || ($urandom_range(0, 99) < recv_idle);
    end

    // long receiver hold-off while the sender keeps pushing
    initial
    begin
        int base;
        while (stim_phase != 2)
            @(negedge clk);
        base = taken_cnt;
        while (taken_cnt < base + 20)
            @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        result_t want;
        in_took = in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_took)
            begin
                predict_byte(in_byte, in_last);
                taken_cnt++;
            end
            if (res_valid && !res_stall)
            begin
                if (exp_q.size() == 0)
                    flag_error($sformatf("unexpected transaction: byte %h valid %b last %b count %h",
                                         out_byte, out_valid, out_last, changed_count));
                else
                begin
                    want = exp_q.pop_front();
                    if (out_byte !== want.data || out_valid !== want.vld ||
                        out_last !== want.last || changed_count !== want.cnt)
                        flag_error($sformatf({"mismatch: expected byte %h valid %b last %b ",
                                              "count %h, got byte %h valid %b last %b count %h"},
                                             want.data, want.vld, want.last, want.cnt,
                                             out_byte, out_valid, out_last, changed_count));
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        send_idle = 24;
        recv_idle = 88;
        text_q = '{8'h00, 8'hFF, CH_TAB, CH_CR, CH_LF};
        seal_string();
        text_q = '{LEAD_C2, CONT_A0, LEAD_C2, CONT_AD, LEAD_E1, CONT_9A, CONT_80};
        seal_string();
        text_q = '{LEAD_E3, CONT_80, CONT_80, LEAD_E2, CONT_81, 8'hA5,
                   LEAD_EF, CONT_BB, CONT_BF};
        seal_string();
        text_q = '{LEAD_E2, CONT_80};
        seal_string();
        text_q = '{LEAD_C2, LEAD_E2, CONT_80, 8'h41};
        seal_string();
        run_random(140);
        drain_all();

        @(posedge clk);
        send_idle = 88;
        recv_idle = 24;
        run_random(130);
        drain_all();

        @(posedge clk);
        send_idle = 0;
        recv_idle = 0;
        stim_phase = 2;
        run_random(140);
        drain_all();

        repeat (20) @(negedge clk);
        if (exp_q.size() != 0)
            flag_error($sformatf("%0d expected transactions never arrived", exp_q.size()));
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
